FILE: rtl/rpm_pkg.sv
// Shared types and constants for the RMS and peak level meter.
`timescale 1ns / 1ps

package rpm_pkg;

    // Width of the energy accumulator and of the shared arithmetic unit.
    localparam int ENERGY_BITS = 64;

    // Level outputs in tenths of a percent of full scale.
    localparam int PM_BITS  = 10;
    localparam int PM_SCALE = 1000;

    // Action codes of an input transfer.
    localparam logic [1:0] ACT_START  = 2'd0;
    localparam logic [1:0] ACT_SAMPLE = 2'd1;
    localparam logic [1:0] ACT_FINISH = 2'd2;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op                op;
        logic [ENERGY_BITS-1:0] a;
        logic [ENERGY_BITS-1:0] b;
    } t_alu_req;

endpackage

FILE: rtl/rpm_alu.sv
// Shared 64-bit add and subtract unit with carry or borrow out.
`timescale 1ns / 1ps

module rpm_alu
    import rpm_pkg::*;
(
    input  t_alu_req               i_req,
    output logic [ENERGY_BITS:0]   o_res
);

    // The top bit is the carry for an add and the borrow (a < b) for a subtract.
    always_comb begin
        case (i_req.op)
            ALU_ADD: o_res = {1'b0, i_req.a} + {1'b0, i_req.b};
            ALU_SUB: o_res = {1'b0, i_req.a} - {1'b0, i_req.b};
            default: o_res = '0;
        endcase
    end

endmodule

FILE: rtl/rpm_mul.sv
// Registered unsigned multiplier used for squaring and level scaling.
`timescale 1ns / 1ps

module rpm_mul #(
    parameter int WIDTH = 16
) (
    input  logic               i_clk,
    input  logic [WIDTH-1:0]   i_a,
    input  logic [WIDTH-1:0]   i_b,
    output logic [2*WIDTH-1:0] o_prod
);

    logic [2*WIDTH-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

FILE: rtl/rms_peak_level_meter_core.sv
// Top level of the RMS and peak level meter with its sequencer.
`timescale 1ns / 1ps

// Channel  Direction  Handshake               Payload
// input    in         i_in_valid / o_in_stall  i_action, i_sample
// result   out        o_out_valid / i_out_stall o_count, o_energy, o_peak_level,
//                                              o_rms_level, o_rms_permille,
//                                              o_peak_permille
//
// A start transfer clears and arms the meter; an armed sample with the count below its
// maximum is squared, then accumulated; any other sample leaves the sequencer idle.
// A finish with a nonzero count runs 64 divide and 32 square root steps on the
// shared subtractor, then scaling and load; with a zero count only scaling and load.
// Synchronous active-low reset disarms and clears the meter. A stalled result
// waits in the output register; samples and starts go on, a later finish waits.

module rms_peak_level_meter_core
    import rpm_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [1:0]             i_action,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [COUNT_BITS-1:0]  o_count,
    output logic [ENERGY_BITS-1:0] o_energy,
    output logic [SAMPLE_BITS-1:0] o_peak_level,
    output logic [SAMPLE_BITS-1:0] o_rms_level,
    output logic [PM_BITS-1:0]     o_rms_permille,
    output logic [PM_BITS-1:0]     o_peak_permille
);

    // The multiplier must hold both a full magnitude and the scale factor.
    localparam int MUL_W = (SAMPLE_BITS > PM_BITS) ? SAMPLE_BITS : PM_BITS;
    localparam logic [COUNT_BITS-1:0]  CNT_MAX  = '1;
    // Rounding term of the level scaling, half of one output step.
    localparam logic [ENERGY_BITS-1:0] HALF_LSB = ENERGY_BITS'(1) << (SAMPLE_BITS - 2);
    localparam logic [ENERGY_BITS-1:0] BIT_INIT = ENERGY_BITS'(1) << (ENERGY_BITS - 2);
    localparam logic [5:0] DIV_LAST  = 6'(ENERGY_BITS - 1);
    localparam logic [5:0] SQRT_LAST = 6'(ENERGY_BITS / 2 - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_ACC,
        S_DIV,
        S_SQRT,
        S_RMUL,
        S_RADD,
        S_PADD,
        S_LOAD
    } t_state;

    t_state                 r_state;
    logic                   r_armed;
    logic [ENERGY_BITS-1:0] r_energy;
    logic [COUNT_BITS-1:0]  r_count;
    logic [SAMPLE_BITS-1:0] r_peak;
    logic [SAMPLE_BITS-1:0] r_mag;
    logic [ENERGY_BITS-1:0] r_num;
    logic [COUNT_BITS-1:0]  r_rem;
    logic [ENERGY_BITS-1:0] r_root;
    logic [ENERGY_BITS-1:0] r_bit;
    logic [5:0]             r_step;
    logic [SAMPLE_BITS-1:0] r_rms;
    logic [PM_BITS-1:0]     r_rms_pm;
    logic [PM_BITS-1:0]     r_pk_pm;
    logic                   r_out_valid;
    logic [COUNT_BITS-1:0]  r_o_count;
    logic [ENERGY_BITS-1:0] r_o_energy;
    logic [SAMPLE_BITS-1:0] r_o_peak;
    logic [SAMPLE_BITS-1:0] r_o_rms;
    logic [PM_BITS-1:0]     r_o_rms_pm;
    logic [PM_BITS-1:0]     r_o_pk_pm;

    logic                   w_accept;
    logic [SAMPLE_BITS-1:0] w_mag;
    logic [MUL_W-1:0]       w_mul_a;
    logic [MUL_W-1:0]       w_mul_b;
    logic [2*MUL_W-1:0]     w_prod;
    t_alu_req               w_alu_req;
    logic [ENERGY_BITS:0]   w_alu_res;
    logic                   w_borrow;
    logic [COUNT_BITS:0]    w_shift;
    logic [ENERGY_BITS-1:0] w_root_next;
    logic [PM_BITS-1:0]     w_pm;

    // Input transfers are taken only while the sequencer is idle.
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    // Magnitude of the two's complement sample; the most negative code maps to
    // full scale, which still fits unsigned in the sample width.
    assign w_mag = i_sample[SAMPLE_BITS-1] ? (~i_sample + SAMPLE_BITS'(1)) : i_sample;

    // The multiplier squares a sample, then scales the RMS and the peak.
    // Its product is registered, so it appears in the cycle after its operands are presented.
    always_comb begin
        case (r_state)
            S_RMUL: begin
                w_mul_a = MUL_W'(r_rms);
                w_mul_b = MUL_W'(PM_SCALE);
            end
            S_RADD: begin
                w_mul_a = MUL_W'(r_peak);
                w_mul_b = MUL_W'(PM_SCALE);
            end
            default: begin
                w_mul_a = MUL_W'(r_mag);
                w_mul_b = MUL_W'(r_mag);
            end
        endcase
    end

    rpm_mul #(
        .WIDTH (MUL_W)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // Partial remainder with the next dividend bit brought in.
    assign w_shift = {r_rem, r_num[ENERGY_BITS-1]};

    // The shared unit serves energy accumulation, the restoring divide, the
    // digit-by-digit square root and the rounding of both levels.
    always_comb begin
        case (r_state)
            S_ACC: begin
                w_alu_req.op = ALU_ADD;
                w_alu_req.a  = r_energy;
                w_alu_req.b  = ENERGY_BITS'(w_prod);
            end
            S_DIV: begin
                w_alu_req.op = ALU_SUB;
                w_alu_req.a  = ENERGY_BITS'(w_shift);
                w_alu_req.b  = ENERGY_BITS'(r_count);
            end
            S_SQRT: begin
                // The trial bit always lies below the set bits of the root,
                // so the OR equals the sum.
                w_alu_req.op = ALU_SUB;
                w_alu_req.a  = r_num;
                w_alu_req.b  = r_root | r_bit;
            end
            S_RADD, S_PADD: begin
                w_alu_req.op = ALU_ADD;
                w_alu_req.a  = ENERGY_BITS'(w_prod);
                w_alu_req.b  = HALF_LSB;
            end
            default: begin
                w_alu_req.op = ALU_ADD;
                w_alu_req.a  = '0;
                w_alu_req.b  = '0;
            end
        endcase
    end

    rpm_alu u_alu (
        .i_req (w_alu_req),
        .o_res (w_alu_res)
    );

    assign w_borrow    = w_alu_res[ENERGY_BITS];
    assign w_root_next = w_borrow ? (r_root >> 1) : ((r_root >> 1) | r_bit);
    assign w_pm        = w_alu_res[SAMPLE_BITS-1 +: PM_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_armed     <= 1'b0;
            r_energy    <= '0;
            r_count     <= '0;
            r_peak      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The load step handles its own release of the output register.
            if (r_out_valid && !i_out_stall && (r_state != S_LOAD)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_action)
                            ACT_START: begin
                                r_energy <= '0;
                                r_count  <= '0;
                                r_peak   <= '0;
                                r_armed  <= 1'b1;
                            end
                            ACT_SAMPLE: begin
                                if (r_armed) begin
                                    if (w_mag > r_peak) begin
                                        r_peak <= w_mag;
                                    end
                                    if (r_count != CNT_MAX) begin
                                        r_mag   <= w_mag;
                                        r_state <= S_SQ;
                                    end
                                end
                            end
                            ACT_FINISH: begin
                                r_armed <= 1'b0;
                                if (r_count == '0) begin
                                    r_rms   <= '0;
                                    r_state <= S_RMUL;
                                end else begin
                                    r_rem   <= '0;
                                    r_num   <= r_energy;
                                    r_step  <= DIV_LAST;
                                    r_state <= S_DIV;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SQ: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    // Saturate on carry out of the energy sum.
                    r_energy <= w_borrow ? '1 : w_alu_res[ENERGY_BITS-1:0];
                    r_count  <= r_count + COUNT_BITS'(1);
                    r_state  <= S_IDLE;
                end
                S_DIV: begin
                    r_rem <= w_borrow ? w_shift[COUNT_BITS-1:0]
                                      : w_alu_res[COUNT_BITS-1:0];
                    r_num <= {r_num[ENERGY_BITS-2:0], !w_borrow};
                    if (r_step == '0) begin
                        r_root  <= '0;
                        r_bit   <= BIT_INIT;
                        r_step  <= SQRT_LAST;
                        r_state <= S_SQRT;
                    end else begin
                        r_step <= r_step - 6'd1;
                    end
                end
                S_SQRT: begin
                    if (!w_borrow) begin
                        r_num <= w_alu_res[ENERGY_BITS-1:0];
                    end
                    r_root <= w_root_next;
                    r_bit  <= r_bit >> 2;
                    if (r_step == '0) begin
                        r_rms   <= w_root_next[SAMPLE_BITS-1:0];
                        r_state <= S_RMUL;
                    end else begin
                        r_step <= r_step - 6'd1;
                    end
                end
                S_RMUL: begin
                    r_state <= S_RADD;
                end
                S_RADD: begin
                    r_rms_pm <= w_pm;
                    r_state  <= S_PADD;
                end
                S_PADD: begin
                    r_pk_pm <= w_pm;
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    // Wait until the output register is free, then load it.
                    if (!r_out_valid || !i_out_stall) begin
                        r_o_count   <= r_count;
                        r_o_energy  <= r_energy;
                        r_o_peak    <= r_peak;
                        r_o_rms     <= r_rms;
                        r_o_rms_pm  <= r_rms_pm;
                        r_o_pk_pm   <= r_pk_pm;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_count         = r_o_count;
    assign o_energy        = r_o_energy;
    assign o_peak_level    = r_o_peak;
    assign o_rms_level     = r_o_rms;
    assign o_rms_permille  = r_o_rms_pm;
    assign o_peak_permille = r_o_pk_pm;

    // The divide only runs with a nonzero divisor.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_count != '0))
        else $error("divide running with zero count");

    // The partial remainder of the restoring divide stays below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_count))
        else $error("divide remainder out of range");

    // Exactly one trial bit is live during the square root.
    a_bit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> $onehot(r_bit))
        else $error("square root trial bit lost");

    // A start transfer leaves the meter armed with cleared accumulators.
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_action == ACT_START) |=>
        (r_armed && r_count == '0 && r_energy == '0 && r_peak == '0))
        else $error("start did not clear the accumulators");

    // A result only appears after the load step.
    a_load_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_LOAD))
        else $error("result presented outside the load step");

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the RMS and peak level meter core.
`timescale 1ns / 1ps

module tb_top;
    import rpm_pkg::*;

    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 32;

    // The package names the three real actions; the fourth code must be ignored.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // A finish with a nonzero count runs the whole divide and square root; to that add the
    // longest plausible sender gap and receiver stall, then leave a wide margin.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 110;

    // One finish report, field for field as the block presents it.
    typedef struct packed {
        logic [COUNT_BITS-1:0]  count;
        logic [ENERGY_BITS-1:0] energy;
        logic [SAMPLE_BITS-1:0] peak;
        logic [SAMPLE_BITS-1:0] rms;
        logic [PM_BITS-1:0]     rms_pm;
        logic [PM_BITS-1:0]     peak_pm;
    } t_meter_report;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic [1:0]             i_action = ACT_START;
    logic [SAMPLE_BITS-1:0] i_sample = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [COUNT_BITS-1:0]  o_count;
    logic [ENERGY_BITS-1:0] o_energy;
    logic [SAMPLE_BITS-1:0] o_peak_level;
    logic [SAMPLE_BITS-1:0] o_rms_level;
    logic [PM_BITS-1:0]     o_rms_permille;
    logic [PM_BITS-1:0]     o_peak_permille;

    rms_peak_level_meter_core #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_sample       (i_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_count        (o_count),
        .o_energy       (o_energy),
        .o_peak_level   (o_peak_level),
        .o_rms_level    (o_rms_level),
        .o_rms_permille (o_rms_permille),
        .o_peak_permille(o_peak_permille)
    );

    // 12 ns clock period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow copy of the meter state, updated at each accepted input transfer.
    logic                   meter_armed = 1'b0;
    logic [ENERGY_BITS-1:0] meter_energy = '0;
    logic [COUNT_BITS-1:0]  meter_count = '0;
    logic [SAMPLE_BITS-1:0] meter_peak = '0;

    // Reports that a finish has promised but the block has not yet delivered.
    t_meter_report pending_reports[$];

    int sender_idle_pct = 0;
    int out_stall_pct   = 0;
    int counted_items   = 0;   // accepted transfers that the block acts on
    int in_transfers    = 0;
    int reports_checked = 0;
    int mismatch_count  = 0;
    int quiet_cycles    = 0;

    // Integer square root, settled one result bit at a time from the top.
    function automatic logic [63:0] int_root(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Level in tenths of a percent of full scale, rounded half up.
    function automatic logic [PM_BITS-1:0] tenths_of_pct(input logic [63:0] x);
        logic [63:0] scaled;
        scaled = (x * PM_SCALE + (64'd1 << (SAMPLE_BITS - 2))) >> (SAMPLE_BITS - 1);
        return scaled[PM_BITS-1:0];
    endfunction

    // Applies one accepted transfer to the shadow state and queues any report.
    task automatic meter_apply(input logic [1:0] act, input logic [SAMPLE_BITS-1:0] smp);
        logic [SAMPLE_BITS:0]   mag;
        logic [ENERGY_BITS-1:0] sq;
        logic [63:0]            root;
        t_meter_report          rpt;
        case (act)
            ACT_START: begin
                meter_energy = '0;
                meter_count  = '0;
                meter_peak   = '0;
                meter_armed  = 1'b1;
                counted_items++;
            end
            ACT_SAMPLE: begin
                if (meter_armed) begin
                    // Magnitude of the sample; the most negative code gives full scale.
                    mag = smp[SAMPLE_BITS-1] ? ({1'b1, {SAMPLE_BITS{1'b0}}} - {1'b0, smp})
                                             : {1'b0, smp};
                    if (meter_count != {COUNT_BITS{1'b1}}) begin
                        sq = ENERGY_BITS'(mag) * ENERGY_BITS'(mag);
                        if (meter_energy > ~sq) begin
                            meter_energy = '1;
                        end else begin
                            meter_energy = meter_energy + sq;
                        end
                        meter_count = meter_count + COUNT_BITS'(1);
                    end
                    if (mag > {1'b0, meter_peak}) begin
                        meter_peak = mag[SAMPLE_BITS-1:0];
                    end
                    counted_items++;
                end
            end
            ACT_FINISH: begin
                meter_armed = 1'b0;
                root = (meter_count != 0) ? int_root(meter_energy / meter_count) : 64'd0;
                rpt.count   = meter_count;
                rpt.energy  = meter_energy;
                rpt.peak    = meter_peak;
                rpt.rms     = root[SAMPLE_BITS-1:0];
                rpt.rms_pm  = tenths_of_pct(root);
                rpt.peak_pm = tenths_of_pct(64'(meter_peak));
                pending_reports.push_back(rpt);
                counted_items++;
            end
            default: begin
            end
        endcase
    endtask

    // Presents one input transfer, idling first at the current sender rate.
    // Valid is left high on return so that back-to-back transfers never see it
    // lowered and raised within one time step.
    task automatic send_item(input logic [1:0] act, input logic [SAMPLE_BITS-1:0] smp);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            i_action   <= 2'($urandom_range(3));
            i_sample   <= SAMPLE_BITS'($urandom);
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_sample   <= smp;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        in_transfers++;
        meter_apply(act, smp);
    endtask

    // Sample values weighted toward the extremes and toward near-silence.
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(7))
            0: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            1: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            2: return SAMPLE_BITS'($urandom_range(16)) - SAMPLE_BITS'(8);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Finish right out of reset reports the cleared accumulators; samples and
    // the unused action code while disarmed must change nothing.
    task automatic test_after_reset();
        send_item(ACT_FINISH, 16'h0000);
        send_item(ACT_SAMPLE, 16'h8000);
        send_item(ACT_UNUSED, 16'h7FFF);
        send_item(ACT_FINISH, 16'hFFFF);
    endtask

    // Full-scale negative and positive, zero, minus one and one in one window,
    // then a window with no samples at all, which must give an RMS of zero.
    task automatic test_sample_extremes();
        send_item(ACT_START, 16'hFFFF);
        send_item(ACT_SAMPLE, 16'h8000);
        send_item(ACT_SAMPLE, 16'h7FFF);
        send_item(ACT_SAMPLE, 16'h0000);
        send_item(ACT_SAMPLE, 16'hFFFF);
        send_item(ACT_SAMPLE, 16'h0001);
        send_item(ACT_FINISH, 16'h0000);
        send_item(ACT_START, 16'h0000);
        send_item(ACT_FINISH, 16'h8000);
    endtask

    // The unused code inside a window, a repeated finish that must report the
    // held totals, a sample after finish, and a double start.
    task automatic test_ignored_and_repeated();
        send_item(ACT_START, 16'h5555);
        send_item(ACT_SAMPLE, 16'h8000);
        send_item(ACT_UNUSED, 16'h7FFF);
        send_item(ACT_FINISH, 16'hAAAA);
        send_item(ACT_FINISH, 16'h0000);
        send_item(ACT_SAMPLE, 16'h7FFF);
        send_item(ACT_FINISH, 16'h0000);
        send_item(ACT_START, 16'h0000);
        send_item(ACT_START, 16'h0000);
        send_item(ACT_SAMPLE, 16'h1234);
        send_item(ACT_FINISH, 16'h0000);
    endtask

    // Mostly well-formed measurement windows with random content, the rest
    // random actions so that disarmed samples and stray finishes also occur.
    task automatic test_random_windows(input int idle_pct, input int stall_pct, input int budget);
        int target;
        int n;
        sender_idle_pct = idle_pct;
        out_stall_pct   = stall_pct;
        target = counted_items + budget;
        while (counted_items < target) begin
            if ($urandom_range(99) < 85) begin
                send_item(ACT_START, SAMPLE_BITS'($urandom));
                n = ($urandom_range(9) == 0) ? $urandom_range(80) : $urandom_range(24);
                repeat (n) begin
                    if ($urandom_range(49) == 0) begin
                        send_item(ACT_UNUSED, SAMPLE_BITS'($urandom));
                    end
                    send_item(ACT_SAMPLE, pick_sample());
                end
                send_item(ACT_FINISH, SAMPLE_BITS'($urandom));
            end else begin
                send_item(2'($urandom_range(3)), pick_sample());
            end
        end
    endtask

    // The receiver stalls at the current rate, decided afresh at every edge.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    task automatic check_field(input string what, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("report %0d, %s: expected %0d, got %0d",
                         reports_checked, what, exp_v, act_v);
            end
        end
    endtask

    // Every result transfer is matched against the oldest pending report.
    always @(posedge i_clk) begin : report_checker
        t_meter_report exp_rpt;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("result transfer with no report pending, count %0d", o_count);
                end
            end else begin
                exp_rpt = pending_reports.pop_front();
                check_field("count", 64'(exp_rpt.count), 64'(o_count));
                check_field("energy", exp_rpt.energy, o_energy);
                check_field("peak_level", 64'(exp_rpt.peak), 64'(o_peak_level));
                check_field("rms_level", 64'(exp_rpt.rms), 64'(o_rms_level));
                check_field("rms_permille", 64'(exp_rpt.rms_pm), 64'(o_rms_permille));
                check_field("peak_permille", 64'(exp_rpt.peak_pm), 64'(o_peak_permille));
                reports_checked++;
            end
        end
    end

    // Ends a hung run: counts consecutive cycles in which neither channel moves.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_top NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_sample_extremes();
        test_ignored_and_repeated();

        // Four traffic mixes: free flowing, slow sender, slow receiver, both a little.
        test_random_windows(0, 0, 300);
        test_random_windows(69, 0, 300);
        test_random_windows(0, 69, 300);
        test_random_windows(11, 11, 300);

        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) begin
            @(posedge i_clk);
        end
        // Wait long enough for a stray result from a finish to surface.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d input transfers and %0d finish reports under four",
                 in_transfers, reports_checked);
        $display("sender and receiver idle mixes; %0d mismatches.", mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/rpm_pkg.sv
rtl/rpm_alu.sv
rtl/rpm_mul.sv
rtl/rms_peak_level_meter_core.sv
test/tb_top.sv
